// ===== src/hce_pkg.sv =====
// hill cipher encryption: shared constants, command codes and item types
// no dependencies; used by every module of the block and by its checker
package hce_pkg;

  localparam int unsigned MaxN        = 4;
  localparam int unsigned AlphabetMax = 128;
  localparam int unsigned CharCodes   = 256;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned PosW     = 7;
  localparam int unsigned CharW    = 8;
  localparam int unsigned BlkW     = 3;
  localparam int unsigned AlphW    = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam int unsigned IdxW     = $clog2(MaxN);
  localparam int unsigned CntW     = $clog2(MaxN + 1);
  localparam int unsigned KeyDepth = MaxN * MaxN;
  localparam int unsigned KeyAW    = $clog2(KeyDepth);
  localparam int unsigned ProdW    = 2 * PosW;
  // even width, the remainder unit takes two bits a step
  localparam int unsigned AccW     = ((ProdW + $clog2(MaxN) + 1) / 2) * 2;
  localparam int unsigned ModSteps = AccW / 2;
  localparam int unsigned ModCntW  = $clog2(ModSteps);

  localparam logic [BlkW-1:0]  BlkReset  = 3'd2;
  localparam logic [AlphW-1:0] AlphReset = 8'd66;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD_ALPHA = 2'd0,
    CMD_LOAD_KEY   = 2'd1,
    CMD_DATA       = 2'd2,
    CMD_END        = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_SIZE    = 1'b0,
    CFG_ALPHABET_SIZE = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_LOOKUP = 3'd1,
    ST_MAC    = 3'd2,
    ST_MOD    = 3'd3,
    ST_OUT    = 3'd4
  } hce_state_e;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [PosW-1:0]  position;
    logic [CharW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             last_of_block;
  } out_item_t;

endpackage

// ===== src/hill_cipher_encrypt.sv =====
// hill cipher encryption over a loadable alphabet; load, key, data and end commands
// load and key commands leave the input open; a data character that leaves the block open stalls it through the lookup
// a full block of n characters is encrypted one row at a time: key memory reads and
// multiply-accumulate for the row, reduction in the shared remainder unit, then output
// the output register lets the next item in while the last character of a block waits
// reset: character table valid bits cleared at once, no clearing pass; block_size 2, m 66
module hill_cipher_encrypt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  hce_pkg::in_item_t            in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output hce_pkg::out_item_t           out_o,
  input  logic                         cfg_we_i,
  input  logic [hce_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hce_pkg::CfgDataW-1:0] cfg_data_i
);
  import hce_pkg::*;

  hce_state_e       state_q, state_d;
  logic [BlkW-1:0]  block_size_q;
  logic [AlphW-1:0] alphabet_size_q;
  logic [CntW-1:0]  n_eff;
  logic [AlphW-1:0] m_eff;

  logic [CntW-1:0]  fill_q, fill_d, fill_inc;
  logic             pending_q, pending_d;
  logic [IdxW-1:0]  row_q, row_d;
  logic [CntW-1:0]  col_q, col_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]  rd_col_q, rd_col_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [PosW-1:0]  buf_q [MaxN];
  logic             buf_we;
  logic             out_valid_q;
  out_item_t        out_q;
  logic             out_load;
  logic             out_free;
  logic             last_row;

  // memories and their read registers
  logic [PosW-1:0]  c2p_mem [CharCodes];
  logic             c2p_vld_q [CharCodes];
  logic [CharW-1:0] p2c_mem [AlphabetMax];
  logic [PosW-1:0]  key_mem [KeyDepth];
  logic [PosW-1:0]  c2p_rd_q;
  logic             c2p_hit_q;
  logic [PosW-1:0]  key_rd_q;
  logic [CharW-1:0] p2c_rd_q;

  logic             in_acc;
  logic [KeyAW-1:0] key_addr;
  logic [PosW-1:0]  buf_op;
  logic [ProdW-1:0] prod;
  logic             mod_start;
  logic             mod_done;
  logic [PosW-1:0]  mod_rem;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    if (block_size_q == '0) begin
      n_eff = CntW'(1);
    end else if (CntW'(block_size_q) > CntW'(MaxN)) begin
      n_eff = CntW'(MaxN);
    end else begin
      n_eff = CntW'(block_size_q);
    end
    if (alphabet_size_q == '0) begin
      m_eff = AlphW'(1);
    end else if (alphabet_size_q > AlphW'(AlphabetMax)) begin
      m_eff = AlphW'(AlphabetMax);
    end else begin
      m_eff = alphabet_size_q;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q    <= BlkReset;
      alphabet_size_q <= AlphReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BLOCK_SIZE:    block_size_q    <= cfg_data_i[BlkW-1:0];
        CFG_ALPHABET_SIZE: alphabet_size_q <= cfg_data_i[AlphW-1:0];
        default: ;
      endcase
    end
  end

  // key address row * n + column, read in the cycle before the accumulate
  assign key_addr = KeyAW'(row_q) * KeyAW'(n_eff) + KeyAW'(col_q[IdxW-1:0]);

  // entries past the fill count act as pad position 0
  assign buf_op   = (CntW'(rd_col_q) < fill_q) ? buf_q[rd_col_q] : '0;
  assign prod     = ProdW'(key_rd_q) * ProdW'(buf_op);
  assign fill_inc = fill_q + CntW'(fill_q < CntW'(MaxN));
  assign last_row = (CntW'(row_q) == n_eff - CntW'(1));

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    pending_d = pending_q;
    row_d     = row_q;
    col_d     = col_q;
    acc_d     = acc_q;
    rd_vld_d  = 1'b0;
    rd_col_d  = col_q[IdxW-1:0];
    buf_we    = 1'b0;
    mod_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(in_i.command))
            CMD_DATA: state_d = ST_LOOKUP;
            CMD_END: begin
              if (fill_q != '0 || pending_q) begin
                row_d   = '0;
                col_d   = '0;
                acc_d   = '0;
                state_d = ST_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOOKUP: begin
        if (!c2p_hit_q) begin
          pending_d = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          buf_we = (fill_q < CntW'(MaxN));
          fill_d = fill_inc;
          if (fill_inc >= n_eff) begin
            row_d   = '0;
            col_d   = '0;
            acc_d   = '0;
            state_d = ST_MAC;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MAC: begin
        if (col_q < n_eff) begin
          rd_vld_d = 1'b1;
          col_d    = col_q + CntW'(1);
        end
        if (rd_vld_q) begin
          acc_d = acc_q + AccW'(prod);
          if (CntW'(rd_col_q) == n_eff - CntW'(1)) begin
            mod_start = 1'b1;
            state_d   = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (last_row) begin
            fill_d    = '0;
            pending_d = 1'b0;
            state_d   = ST_IDLE;
          end else begin
            row_d   = row_q + IdxW'(1);
            col_d   = '0;
            acc_d   = '0;
            state_d = ST_MAC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      pending_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      pending_q <= pending_d;
      rd_vld_q  <= rd_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    col_q    <= col_d;
    acc_q    <= acc_d;
    rd_col_q <= rd_col_d;
    if (buf_we) begin
      buf_q[fill_q[IdxW-1:0]] <= c2p_rd_q;
    end
    if (out_load) begin
      out_q.out_char      <= p2c_rd_q;
      out_q.last_of_block <= last_row;
    end
  end

  // character to position valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CharCodes; i++) begin
        c2p_vld_q[i] <= 1'b0;
      end
    end else if (in_acc && cmd_e'(in_i.command) == CMD_LOAD_ALPHA) begin
      c2p_vld_q[in_i.value] <= 1'b1;
    end
  end

  // table writes from load commands
  always_ff @(posedge clk_i) begin
    if (in_acc && cmd_e'(in_i.command) == CMD_LOAD_ALPHA &&
        32'(in_i.position) < AlphabetMax) begin
      p2c_mem[in_i.position] <= in_i.value;
      c2p_mem[in_i.value]    <= in_i.position;
    end
    if (in_acc && cmd_e'(in_i.command) == CMD_LOAD_KEY &&
        32'(in_i.position) < KeyDepth) begin
      key_mem[in_i.position[KeyAW-1:0]] <= in_i.value[PosW-1:0];
    end
  end

  // synchronous reads
  always_ff @(posedge clk_i) begin
    c2p_rd_q  <= c2p_mem[in_i.value];
    c2p_hit_q <= c2p_vld_q[in_i.value];
    key_rd_q  <= key_mem[key_addr];
    p2c_rd_q  <= p2c_mem[mod_rem];
  end

  hce_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (acc_d),
    .modulus_i  (m_eff),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== src/hce_mod.sv =====
// remainder unit: reduces a row sum modulo the alphabet size, two bits a cycle
// depends on hce_pkg
module hce_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hce_pkg::AccW-1:0]  dividend_i,
  input  logic [hce_pkg::AlphW-1:0] modulus_i,
  output logic                      done_o,
  output logic [hce_pkg::PosW-1:0]  rem_o
);
  import hce_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [ModCntW-1:0] cnt_q;
  logic [AccW-1:0]    div_q;
  logic [PosW-1:0]    rem_q;
  logic [PosW:0]      t1;
  logic [PosW:0]      t2;
  logic [PosW-1:0]    rem_d;

  // two restoring steps; remainder stays below the modulus, so one subtract each
  always_comb begin
    t1 = {rem_q, div_q[AccW-1]};
    if (t1 >= modulus_i) begin
      t1 = t1 - modulus_i;
    end
    t2 = {t1[PosW-1:0], div_q[AccW-2]};
    if (t2 >= modulus_i) begin
      t2 = t2 - modulus_i;
    end
    rem_d = t2[PosW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + ModCntW'(1);
        if (cnt_q == ModCntW'(ModSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      div_q <= {div_q[AccW-3:0], 2'b00};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/hce_checker.sv =====
// port-level checks for hill_cipher_encrypt, attached by bind
// depends on hce_pkg and the top level's ports
module hce_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input hce_pkg::in_item_t  in_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input hce_pkg::out_item_t out_o
);
  import hce_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("output item changed while stalled");

  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_i.command == CMD_DATA |=> in_stall_o)
    else $error("data item did not hold off the next item");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_i.command == CMD_LOAD_ALPHA || in_i.command == CMD_LOAD_KEY) |=> !in_stall_o)
    else $error("load item blocked the input");

  a_mid_block_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.last_of_block |-> in_stall_o)
    else $error("input open in the middle of a block");

endmodule

bind hill_cipher_encrypt hce_checker u_hce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
